// ===== sv/midi_channel_message_parser_defines.svh =====
// Assertion macros for the MIDI channel message parser checker.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MCP_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcp checker: property failed");

// Next-cycle implication.
`define MCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcp checker: property failed");

`endif

// ===== sv/mcp_pkg.sv =====
// Types and constants shared by the MIDI channel message parser.
`default_nettype none
package mcp_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE_OFF   = 3'd0,
    KIND_NOTE_ON    = 3'd1,
    KIND_AFTERTOUCH = 3'd2,
    KIND_CONTROL    = 3'd3,
    KIND_PROGRAM    = 3'd4,
    KIND_BEND       = 3'd5
  } event_kind_e;

  // High nibble of a status byte
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_POLY_AT   = 4'hA;
  localparam logic [3:0] ST_CONTROL   = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_CHAN_PRES = 4'hD;
  localparam logic [3:0] ST_BEND      = 4'hE;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_in_packet;
  } byte_word_t;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } event_word_t;

  // Input stage to decoder
  typedef struct packed {
    logic       valid;
    byte_word_t word;
  } stage_t;

  // Decoder to output register
  typedef struct packed {
    logic        load;
    event_word_t word;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/mcp_ifs.sv =====
// Valid/ready channel interfaces for MIDI bytes and parsed events.
`default_nettype none
interface mcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_in_packet;

  modport source (output valid, output byte_value, output last_in_packet, input ready);
  modport sink   (input valid, input byte_value, input last_in_packet, output ready);
endinterface

interface mcp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [3:0] channel;
  logic [6:0] first_data;
  logic [6:0] second_data;

  modport source (output valid, output event_kind, output channel, output first_data,
                  output second_data, input ready);
  modport sink   (input valid, input event_kind, input channel, input first_data,
                  input second_data, output ready);
endinterface
`default_nettype wire

// ===== sv/mcp_in_reg.sv =====
// Input register: holds one MIDI byte word until the decoder takes it.
`default_nettype none
module mcp_in_reg import mcp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcp_byte_if.sink    byte_i,
  input  wire logic   take_i,
  output stage_t      stage_o
);

  logic       valid_q, valid_d;
  byte_word_t word_q;
  logic       load;

  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q.byte_value     <= byte_i.byte_value;
      word_q.last_in_packet <= byte_i.last_in_packet;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.word  = word_q;

endmodule
`default_nettype wire

// ===== sv/mcp_core.sv =====
// Running status state and one-byte decode into channel events.
`default_nettype none
module mcp_core import mcp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire stage_t  stage_i,
  input  wire logic    out_free_i,
  output logic         take_o,
  output result_t      result_o
);

  logic [7:0] status_q, status_d;
  logic [6:0] pend_q, pend_d;
  logic       pend_valid_q, pend_valid_d;

  logic        emit;
  event_word_t ev;
  logic [7:0]  b;

  assign b = stage_i.word.byte_value;

  always_comb begin
    status_d     = status_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    emit         = 1'b0;
    ev.kind        = KIND_NOTE_OFF;
    ev.channel     = status_q[3:0];
    ev.first_data  = pend_q;
    ev.second_data = b[6:0];

    if (b[7]) begin
      // status byte abandons anything half received
      status_d     = b;
      pend_d       = '0;
      pend_valid_d = 1'b0;
    end else if (status_q != 8'h00) begin
      unique case (status_q[7:4])
        ST_PROGRAM: begin
          emit           = 1'b1;
          ev.kind        = KIND_PROGRAM;
          ev.first_data  = b[6:0];
          ev.second_data = '0;
        end
        ST_CHAN_PRES: begin
          emit          = 1'b1;
          ev.kind       = KIND_AFTERTOUCH;
          ev.first_data = '0;
        end
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CONTROL, ST_BEND: begin
          if (!pend_valid_q) begin
            pend_d       = b[6:0];
            pend_valid_d = 1'b1;
          end else begin
            emit         = 1'b1;
            pend_d       = '0;
            pend_valid_d = 1'b0;
            unique case (status_q[7:4])
              ST_NOTE_ON: ev.kind = (b[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
              ST_POLY_AT: ev.kind = KIND_AFTERTOUCH;
              ST_CONTROL: ev.kind = KIND_CONTROL;
              ST_BEND:    ev.kind = KIND_BEND;
              default:    ev.kind = KIND_NOTE_OFF;
            endcase
          end
        end
        default: ;  // system statuses: data skipped
      endcase
    end

    if (stage_i.word.last_in_packet) begin
      status_d     = '0;
      pend_d       = '0;
      pend_valid_d = 1'b0;
    end
  end

  // a word that yields an event waits for room in the output register
  assign take_o          = stage_i.valid && (!emit || out_free_i);
  assign result_o.load   = take_o && emit;
  assign result_o.word   = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
    end else if (take_o) begin
      status_q     <= status_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mcp_out_reg.sv =====
// Output register: holds one event word until the sink takes it.
`default_nettype none
module mcp_out_reg import mcp_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire result_t result_i,
  output logic         free_o,
  mcp_event_if.source  event_o
);

  logic        valid_q, valid_d;
  event_word_t word_q;

  assign free_o = !valid_q || event_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (result_i.load) begin
      valid_d = 1'b1;
    end else if (event_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.load) begin
      word_q <= result_i.word;
    end
  end

  assign event_o.valid       = valid_q;
  assign event_o.event_kind  = word_q.kind;
  assign event_o.channel     = word_q.channel;
  assign event_o.first_data  = word_q.first_data;
  assign event_o.second_data = word_q.second_data;

endmodule
`default_nettype wire

// ===== sv/midi_channel_message_parser.sv =====
// MIDI channel message parser with running status.
// Latency: an event word becomes valid in the cycle after the byte word that completes it is taken.
// Throughput: one byte word per cycle; the decoder stalls only when an event must wait
// for the output register. The input and output registers set this figure.
// Reset: asynchronous, active low; clears running status, pending data byte and both
// register valid flags.
`default_nettype none
module midi_channel_message_parser import mcp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcp_byte_if.sink    byte_i,
  mcp_event_if.source event_o
);

  stage_t  stage;
  result_t result;
  logic    take;
  logic    out_free;

  mcp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .stage_o (stage)
  );

  mcp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .out_free_i (out_free),
    .take_o     (take),
    .result_o   (result)
  );

  mcp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .result_i (result),
    .free_o   (out_free),
    .event_o  (event_o)
  );

endmodule
`default_nettype wire

// ===== sv/mcp_checker.sv =====
// Port-level assertions for the MIDI channel message parser, bound to the top level.
`default_nettype none
`include "midi_channel_message_parser_defines.svh"
module mcp_checker import mcp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       ev_valid_i,
  input wire logic       ev_ready_i,
  input wire logic [2:0] ev_kind_i,
  input wire logic [6:0] ev_second_i
);

  `MCP_ASSERT_NEXT(a_valid_holds, ev_valid_i && !ev_ready_i, ev_valid_i)
  `MCP_ASSERT(a_kind_range, ev_valid_i, ev_kind_i <= KIND_BEND)
  `MCP_ASSERT(a_program_no_second, ev_valid_i && ev_kind_i == KIND_PROGRAM, ev_second_i == 7'd0)
  `MCP_ASSERT(a_note_on_velocity, ev_valid_i && ev_kind_i == KIND_NOTE_ON, ev_second_i != 7'd0)

endmodule

bind midi_channel_message_parser mcp_checker u_mcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .ev_valid_i  (event_o.valid),
  .ev_ready_i  (event_o.ready),
  .ev_kind_i   (event_o.event_kind),
  .ev_second_i (event_o.second_data)
);
`default_nettype wire

// ===== bench/midi_channel_message_parser_test.sv =====
// Self-checking bench for the MIDI channel message parser: byte driver, event monitor, predictor.
module midi_channel_message_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcp_pkg::*;

  localparam logic [3:0] ST_SYSTEM   = 4'hF;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         DRAIN_LIMIT = 2000;
  localparam int         MAX_PRINTS  = 30;

  logic clk_i = 1'b0;
  logic rst_ni;

  mcp_byte_if  byte_if ();
  mcp_event_if event_if ();

  midi_channel_message_parser u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .event_o (event_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] run_status;
  logic [6:0] held_data;
  logic       held_valid;

  byte_word_t  pending_bytes[$];
  event_word_t expected_events[$];

  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  pushed_count = 0;
  int  taken_count = 0;
  int  events_checked = 0;
  int  packets_sent = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  logic taken_q = 1'b0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("ERROR %0t: %s", $realtime, what);
  endtask

  // Advance the parser state by one byte word; queue the event it completes, if any.
  function automatic void predict_event(input logic [7:0] b, input logic last_flag);
    event_word_t ev;
    logic [3:0]  hi;
    hi = run_status[7:4];
    ev.channel = run_status[3:0];
    if (b[7]) begin
      run_status = b;
      held_valid = 1'b0;
      held_data  = '0;
    end else if (run_status != 8'h00) begin
      case (hi)
        ST_PROGRAM: begin
          ev.kind = KIND_PROGRAM;
          ev.first_data = b[6:0];
          ev.second_data = '0;
          expected_events.push_back(ev);
        end
        ST_CHAN_PRES: begin
          ev.kind = KIND_AFTERTOUCH;
          ev.first_data = '0;
          ev.second_data = b[6:0];
          expected_events.push_back(ev);
        end
        ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CONTROL, ST_BEND: begin
          if (!held_valid) begin
            held_data  = b[6:0];
            held_valid = 1'b1;
          end else begin
            case (hi)
              ST_NOTE_OFF: ev.kind = KIND_NOTE_OFF;
              ST_NOTE_ON:  ev.kind = (b[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
              ST_POLY_AT:  ev.kind = KIND_AFTERTOUCH;
              ST_CONTROL:  ev.kind = KIND_CONTROL;
              default:     ev.kind = KIND_BEND;
            endcase
            ev.first_data = held_data;
            ev.second_data = b[6:0];
            expected_events.push_back(ev);
            held_valid = 1'b0;
            held_data  = '0;
          end
        end
        default: ;  // system statuses: data skipped
      endcase
    end
    if (last_flag) begin
      run_status = '0;
      held_data  = '0;
      held_valid = 1'b0;
    end
  endfunction

  // Byte driver: a word stays on the bus until taken.
  always @(negedge clk_i) begin : drive_bytes
    byte_word_t w;
    if (!byte_if.valid || taken_q) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        w = pending_bytes.pop_front();
        byte_if.valid          <= 1'b1;
        byte_if.byte_value     <= w.byte_value;
        byte_if.last_in_packet <= w.last_in_packet;
      end else begin
        byte_if.valid          <= 1'b0;
        byte_if.byte_value     <= 8'($urandom_range(255));
        byte_if.last_in_packet <= 1'($urandom_range(1));
      end
    end
    event_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Monitor: check the event first, then predict from the byte taken this edge.
  always @(posedge clk_i) begin : watch
    event_word_t want;
    cycle_count++;
    taken_q <= rst_ni && byte_if.valid && byte_if.ready;
    if (rst_ni) begin
      if (event_if.valid && event_if.ready) begin
        events_checked++;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d ch %0d d1 %0d d2 %0d",
                                    event_if.event_kind, event_if.channel,
                                    event_if.first_data, event_if.second_data));
        end else begin
          want = expected_events.pop_front();
          if (event_if.event_kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d",
                                      event_if.event_kind, want.kind));
          if (event_if.channel !== want.channel)
            report_mismatch($sformatf("channel %0d, want %0d",
                                      event_if.channel, want.channel));
          if (event_if.first_data !== want.first_data)
            report_mismatch($sformatf("first_data %0d, want %0d",
                                      event_if.first_data, want.first_data));
          if (event_if.second_data !== want.second_data)
            report_mismatch($sformatf("second_data %0d, want %0d",
                                      event_if.second_data, want.second_data));
        end
      end
      if (byte_if.valid && byte_if.ready) begin
        taken_count++;
        predict_event(byte_if.byte_value, byte_if.last_in_packet);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last_flag);
    byte_word_t w;
    w.byte_value = b;
    w.last_in_packet = last_flag;
    pending_bytes.push_back(w);
    pushed_count++;
  endtask

  function automatic logic [6:0] random_data();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [7:0] random_status();
    logic [3:0] hi;
    logic [3:0] ch;
    ch = 4'($urandom_range(15));
    case ($urandom_range(7))
      0:       hi = ST_NOTE_OFF;
      1:       hi = ST_NOTE_ON;
      2:       hi = ST_POLY_AT;
      3:       hi = ST_CONTROL;
      4:       hi = ST_PROGRAM;
      5:       hi = ST_CHAN_PRES;
      6:       hi = ST_BEND;
      default: hi = ST_SYSTEM;
    endcase
    return {hi, ch};
  endfunction

  function automatic int data_needed(input logic [7:0] status);
    case (status[7:4])
      ST_PROGRAM, ST_CHAN_PRES: return 1;
      ST_SYSTEM:                return int'($urandom_range(2));
      default:                  return 2;
    endcase
  endfunction

  // One packet of messages, mostly well formed, using running status at random.
  task automatic send_packet(output int n_bytes);
    logic [7:0] pkt[$];
    logic [7:0] status;
    bit         have_status;
    int         n_msgs;
    int         n_data;
    int         m;
    int         i;
    have_status = 1'b0;
    status = '0;
    n_msgs = int'($urandom_range(1, 5));
    if ($urandom_range(99) < 5) pkt.push_back({1'b0, random_data()});
    for (m = 0; m < n_msgs; m++) begin
      if (!have_status || $urandom_range(99) < 35) begin
        status = random_status();
        pkt.push_back(status);
        have_status = 1'b1;
      end
      n_data = data_needed(status);
      if (n_data > 0 && $urandom_range(99) < 8) n_data--;  // truncated message
      repeat (n_data) pkt.push_back({1'b0, random_data()});
    end
    if ($urandom_range(99) < 5) pkt.push_back(random_status());  // status ends the packet
    for (i = 0; i < pkt.size(); i++) queue_byte(pkt[i], i == pkt.size() - 1);
    n_bytes = pkt.size();
    packets_sent++;
  endtask

  task automatic send_random(input int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
        send_packet(n);
        sent += n;
      end
    end
  endtask

  // Holds the sender off until every byte is taken and every expected event has come back, or DRAIN_LIMIT runs out.
  task automatic drain();
    int waited;
    waited = 0;
    while (taken_count != pushed_count) @(negedge clk_i);
    while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
  endtask

  task automatic send_directed();
    // all kinds, extremes, velocity-zero note on, channel pressure
    queue_byte(8'h90, 1'b0); queue_byte(8'h3C, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h8F, 1'b0); queue_byte(8'h7F, 1'b0); queue_byte(8'h40, 1'b0);
    queue_byte(8'hA3, 1'b0); queue_byte(8'h10, 1'b0); queue_byte(8'h20, 1'b0);
    queue_byte(8'hB5, 1'b0); queue_byte(8'h07, 1'b0); queue_byte(8'h64, 1'b0);
    queue_byte(8'hC9, 1'b0); queue_byte(8'h7F, 1'b0);
    queue_byte(8'hD2, 1'b0); queue_byte(8'h55, 1'b0);
    queue_byte(8'hEA, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h7F, 1'b0);
    // status mid-message, then data under a system status
    queue_byte(8'hE0, 1'b0); queue_byte(8'h30, 1'b0);
    queue_byte(8'hFF, 1'b0); queue_byte(8'h12, 1'b0);
    // incomplete at packet end, status marked last, data with no status
    queue_byte(8'h93, 1'b0); queue_byte(8'h40, 1'b1);
    queue_byte(8'hC4, 1'b1);
    queue_byte(8'h41, 1'b0);
  endtask

  initial begin
    rst_ni = 1'b0;
    run_status = '0;
    held_data  = '0;
    held_valid = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.byte_value = '0;
    byte_if.last_in_packet = 1'b0;
    event_if.ready = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    @(posedge clk_i);
    src_idle_pct = 26;
    snk_idle_pct = 51;
    send_directed();
    send_random(270);
    drain();

    @(posedge clk_i);
    src_idle_pct = 51;
    snk_idle_pct = 26;
    send_random(270);
    drain();

    @(posedge clk_i);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(270);
    drain();
    repeat (8) @(negedge clk_i);

    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", expected_events.size()));
    $display("Summary: %0d bytes in %0d random packets plus directed cases, three stall profiles",
             taken_count, packets_sent);
    $display("Summary: %0d events compared, %0d mismatches", events_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(negedge clk_i);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
